// File: rtl/mrrc_pkg.sv
// shared types, constants and crc helpers for the modbus rtu response checker
package mrrc_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [7:0]  EXC_MASK   = 8'h80;
    localparam logic [7:0]  RST_SLAVE  = 8'd1;
    localparam logic [7:0]  RST_FUNC   = 8'd3;
    localparam logic [2:0]  CNT_SAT    = 3'd4;
    localparam logic [2:0]  CNT_FEED   = 3'd2;

    typedef enum logic {
        REG_EXP_SLAVE = 1'b0,
        REG_EXP_FUNC  = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        FAULT_OK        = 3'd0,
        FAULT_SHORT     = 3'd1,
        FAULT_SLAVE     = 3'd2,
        FAULT_EXCEPTION = 3'd3,
        FAULT_FUNCTION  = 3'd4,
        FAULT_CRC       = 3'd5
    } fault_t;

    // one classified byte handed from the front to the back
    typedef struct packed {
        logic        feed_en;
        logic [7:0]  feed_byte;
        logic        last;
        logic        is_short;
        logic [7:0]  first_byte;
        logic [7:0]  second_byte;
        logic [15:0] recv_crc;
    } byte_op_t;

    typedef struct packed {
        logic        frame_ok;
        fault_t      fault_code;
        logic [15:0] computed_crc;
        logic [15:0] received_crc;
    } verdict_t;

    function automatic logic [15:0] nib_lut(input logic [3:0] idx);
        logic [15:0] v;
        unique case (idx)
            4'h0: v = 16'h0000;
            4'h1: v = 16'hCC01;
            4'h2: v = 16'hD801;
            4'h3: v = 16'h1400;
            4'h4: v = 16'hF001;
            4'h5: v = 16'h3C00;
            4'h6: v = 16'h2800;
            4'h7: v = 16'hE401;
            4'h8: v = 16'hA001;
            4'h9: v = 16'h6C00;
            4'hA: v = 16'h7800;
            4'hB: v = 16'hB401;
            4'hC: v = 16'h5000;
            4'hD: v = 16'h9C01;
            4'hE: v = 16'h8801;
            default: v = 16'h4400;
        endcase
        return v;
    endfunction

    // two nibble steps, low nibble first
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c1;
        c1 = nib_lut(b[3:0] ^ crc[3:0]) ^ {4'h0, crc[15:4]};
        return nib_lut(b[7:4] ^ c1[3:0]) ^ {4'h0, c1[15:4]};
    endfunction

endpackage

// File: rtl/mrrc_front.sv
// front end: byte counting, delay line and header capture per accepted byte
module mrrc_front import mrrc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_fire,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output byte_op_t   op
);

    logic [7:0] d0_reg, d1_reg, first_reg, second_reg;
    logic [2:0] cnt_reg;
    logic [7:0] first_next, second_next;
    logic [2:0] cnt_next;

    always_comb begin
        first_next  = (cnt_reg == 3'd0) ? in_byte : first_reg;
        second_next = (cnt_reg == 3'd1) ? in_byte : second_reg;
        cnt_next    = (cnt_reg < CNT_SAT) ? cnt_reg + 3'd1 : cnt_reg;

        op.feed_en     = (cnt_reg >= CNT_FEED);
        op.feed_byte   = d0_reg;
        op.last        = in_last;
        op.is_short    = (cnt_next < CNT_SAT);
        op.first_byte  = first_next;
        op.second_byte = second_next;
        op.recv_crc    = {in_byte, d1_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d0_reg     <= '0;
            d1_reg     <= '0;
            first_reg  <= '0;
            second_reg <= '0;
            cnt_reg    <= '0;
        end else if (in_fire) begin
            if (in_last) begin
                // frame done, next byte opens a new frame
                d0_reg     <= '0;
                d1_reg     <= '0;
                first_reg  <= '0;
                second_reg <= '0;
                cnt_reg    <= '0;
            end else begin
                d0_reg     <= d1_reg;
                d1_reg     <= in_byte;
                first_reg  <= first_next;
                second_reg <= second_next;
                cnt_reg    <= cnt_next;
            end
        end
    end

endmodule

// File: rtl/mrrc_queue.sv
// short fifo of classified byte operations between front and back
module mrrc_queue import mrrc_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  byte_op_t push_op,
    output logic     full,
    output logic     q_valid,
    input  logic     pop,
    output byte_op_t q_op
);

    byte_op_t            mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   cnt_reg;

    assign full    = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_op    = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + QCNT_W'(1);
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - QCNT_W'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full && !pop |-> !push) else $error("queue push while full");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> q_valid) else $error("queue pop while empty");
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= QCNT_W'(QUEUE_DEPTH)) else $error("queue count out of range");

endmodule

// File: rtl/mrrc_back.sv
// back end: running crc, verdict and output register
module mrrc_back import mrrc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic       cfg_addr,
    input  logic [7:0] cfg_wdata,
    input  logic       q_valid,
    input  byte_op_t   q_op,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output verdict_t   out_data
);

    logic [7:0]  exp_slave_reg, exp_func_reg;
    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic        out_valid_reg;
    verdict_t    out_reg;
    verdict_t    verdict;
    logic        slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign pop       = q_valid && (!q_op.last || slot_free);
    assign crc_next  = q_op.feed_en ? crc_feed(crc_reg, q_op.feed_byte) : crc_reg;

    always_comb begin
        if (q_op.is_short) begin
            verdict.fault_code = FAULT_SHORT;
        end else if (q_op.first_byte != exp_slave_reg) begin
            verdict.fault_code = FAULT_SLAVE;
        end else if ((q_op.second_byte & EXC_MASK) == EXC_MASK) begin
            verdict.fault_code = FAULT_EXCEPTION;
        end else if (q_op.second_byte != exp_func_reg) begin
            verdict.fault_code = FAULT_FUNCTION;
        end else if (crc_next != q_op.recv_crc) begin
            verdict.fault_code = FAULT_CRC;
        end else begin
            verdict.fault_code = FAULT_OK;
        end
        verdict.frame_ok     = (verdict.fault_code == FAULT_OK);
        verdict.computed_crc = crc_next;
        verdict.received_crc = q_op.recv_crc;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_slave_reg <= RST_SLAVE;
            exp_func_reg  <= RST_FUNC;
        end else if (cfg_we) begin
            unique case (reg_idx_t'(cfg_addr))
                REG_EXP_SLAVE: exp_slave_reg <= cfg_wdata;
                REG_EXP_FUNC:  exp_func_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg       <= CRC_INIT;
            out_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                crc_reg <= q_op.last ? CRC_INIT : crc_next;
            end
            if (pop && q_op.last) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && q_op.last) begin
            out_reg <= verdict;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_crc_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && q_op.last |=> crc_reg == CRC_INIT) else $error("crc not restarted");
    a_verdict_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && q_op.last |=> out_valid_reg) else $error("verdict not presented");
    a_ok_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_reg.frame_ok == (out_reg.fault_code == FAULT_OK)))
        else $error("frame_ok disagrees with fault_code");
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_ready |-> !(pop && q_op.last))
        else $error("pending verdict overwritten");

endmodule

// File: rtl/modbus_rtu_response_checker_unit.sv
// top level of the modbus rtu response checker
//
// Input stream: one received frame byte per transaction on s_tdata, with
// s_tlast high on the frame's final byte. Output stream: one verdict per
// frame, sent after the final byte: frame_ok, fault_code, the crc computed
// over all bytes but the last two, and the crc carried by those two bytes.
// Faults are reported in priority order: short, slave, exception, function,
// crc. The config port sets the expected slave address (index 0) and the
// expected function code (index 1); write it only while no frame is in flight.
//
// Throughput is one byte per cycle while the queue is not full. Each byte
// passes the front stage, a four-entry queue and the crc/verdict stage; a
// final byte is written into the queue, and its verdict is then loaded into
// the output register that drives m_tdata.
// When m_tready is low the verdict waits in the output register, the back
// stage stops only at the next final byte, and s_tready drops once the
// queue fills. Reset clears the frame state, the queue and the output valid
// and restores the expected slave to 1 and function to 3.
module modbus_rtu_response_checker_unit import mrrc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] frame_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] frame_ok, [3:1] fault_code, [19:4] computed_crc, [35:20] received_crc
    output logic [39:0] m_tdata
);

    logic     in_fire;
    logic     q_full, q_valid, q_pop;
    byte_op_t front_op, q_op;
    verdict_t out_data;

    assign s_tready = !q_full;
    assign in_fire  = s_tvalid && !q_full;

    mrrc_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_fire (in_fire),
        .in_byte (s_tdata),
        .in_last (s_tlast),
        .op      (front_op)
    );

    mrrc_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (in_fire),
        .push_op (front_op),
        .full    (q_full),
        .q_valid (q_valid),
        .pop     (q_pop),
        .q_op    (q_op)
    );

    mrrc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_op      (q_op),
        .pop       (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata = {4'h0, out_data.received_crc, out_data.computed_crc,
                      out_data.fault_code, out_data.frame_ok};

endmodule

// File: verif/testbench.sv
// self-checking testbench for the modbus rtu response checker
`timescale 1ns / 1ps

module testbench;
    import mrrc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 12;

    typedef logic [7:0] byte_q_t[$];

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    reg_idx_t    cfg_addr;
    logic [7:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] frame_byte
    logic        s_tlast;   // last_byte
    logic        m_tvalid;
    logic        m_tready;
    // [0] frame_ok, [3:1] fault_code, [19:4] computed_crc, [35:20] received_crc
    logic [39:0] m_tdata;

    // predictor copy of the registers and frame state
    logic [7:0]  exp_slave_reg;
    logic [7:0]  exp_func_reg;
    logic [15:0] crc_acc;
    logic [7:0]  lag_bytes [2];
    logic [2:0]  frame_len;
    logic [7:0]  hdr_addr;
    logic [7:0]  hdr_func;

    verdict_t    pending_verdicts[$];
    int          fail_count;
    int          quiet_cycles;
    int          src_idle_pct;
    int          sink_stall_pct;

    modbus_rtu_response_checker_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // bitwise crc-16, reflected polynomial, one byte
    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
        end
        return c;
    endfunction

    function automatic int pick_gap();
        return ($urandom_range(9) == 0) ? $urandom_range(30, 6) : $urandom_range(3, 1);
    endfunction

    // append the crc, low byte first
    function automatic byte_q_t seal(input byte_q_t body);
        logic [15:0] c;
        c = CRC_INIT;
        foreach (body[i]) begin
            c = crc16_step(c, body[i]);
        end
        body.push_back(c[7:0]);
        body.push_back(c[15:8]);
        return body;
    endfunction

    // mostly well-formed responses, the rest broken in one way or noise
    function automatic byte_q_t random_frame();
        byte_q_t    body;
        int         plen;
        int         roll;
        int         idx;
        logic [7:0] fn;
        roll = $urandom_range(99);
        plen = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 0);
        if (roll < 8) begin
            repeat ($urandom_range(12, 1)) body.push_back(8'($urandom_range(255)));
            return body;
        end
        if (roll < 14) begin
            body.push_back($urandom_range(1) ? exp_slave_reg : 8'($urandom_range(255)));
            repeat ($urandom_range(2)) body.push_back(8'($urandom_range(255)));
            return body;
        end
        body.push_back((roll < 20) ? (exp_slave_reg ^ 8'($urandom_range(255, 1))) : exp_slave_reg);
        fn = exp_func_reg;
        if (roll >= 20 && roll < 26) begin
            fn = fn | EXC_MASK;
        end else if (roll >= 26 && roll < 32) begin
            fn = fn ^ 8'($urandom_range(127, 1));
        end
        body.push_back(fn);
        repeat (plen) body.push_back(8'($urandom_range(255)));
        body = seal(body);
        if (roll >= 32 && roll < 40) begin
            idx = body.size() - 1 - $urandom_range(1);
            body[idx] = body[idx] ^ (8'h01 << $urandom_range(7));
        end
        return body;
    endfunction

    task automatic clear_frame_model();
        crc_acc      = CRC_INIT;
        lag_bytes[0] = 8'h00;
        lag_bytes[1] = 8'h00;
        frame_len    = 3'd0;
        hdr_addr     = 8'h00;
        hdr_func     = 8'h00;
    endtask

    // crc runs two bytes behind, so the trailing pair is the received crc
    task automatic predict_frame_byte(input logic [7:0] b, input logic last);
        verdict_t    v;
        logic [15:0] recv;
        fault_t      f;
        if (frame_len >= CNT_FEED) crc_acc = crc16_step(crc_acc, lag_bytes[0]);
        recv = {b, lag_bytes[1]};
        lag_bytes[0] = lag_bytes[1];
        lag_bytes[1] = b;
        if (frame_len == 3'd0) begin
            hdr_addr = b;
        end else if (frame_len == 3'd1) begin
            hdr_func = b;
        end
        if (frame_len < CNT_SAT) frame_len = frame_len + 3'd1;
        if (last) begin
            if (frame_len < CNT_SAT) begin
                f = FAULT_SHORT;
            end else if (hdr_addr != exp_slave_reg) begin
                f = FAULT_SLAVE;
            end else if ((hdr_func & EXC_MASK) == EXC_MASK) begin
                f = FAULT_EXCEPTION;
            end else if (hdr_func != exp_func_reg) begin
                f = FAULT_FUNCTION;
            end else if (crc_acc != recv) begin
                f = FAULT_CRC;
            end else begin
                f = FAULT_OK;
            end
            v.frame_ok     = (f == FAULT_OK);
            v.fault_code   = f;
            v.computed_crc = crc_acc;
            v.received_crc = recv;
            pending_verdicts.push_back(v);
            clear_frame_model();
        end
    endtask

    // called in the time step of a rising edge; returns in the step of acceptance
    task automatic push_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = ($urandom_range(99) < src_idle_pct) ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        predict_frame_byte(b, last);
    endtask

    task automatic send_frame(input byte_q_t frm);
        foreach (frm[i]) begin
            push_byte(frm[i], i == frm.size() - 1);
        end
    endtask

    // drop s_tvalid, wait until every expected verdict is taken, then drain
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_registers(input logic [7:0] slave, input logic [7:0] func);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_EXP_SLAVE;
        cfg_wdata <= slave;
        @(posedge aclk);
        exp_slave_reg = slave;
        cfg_addr  <= REG_EXP_FUNC;
        cfg_wdata <= func;
        @(posedge aclk);
        exp_func_reg = func;
        cfg_we    <= 1'b0;
    endtask

    task automatic run_phase(input logic [7:0] slave, input logic [7:0] func, input int nbytes);
        byte_q_t frm;
        int      sent;
        wait_idle();
        set_registers(slave, func);
        sent = 0;
        while (sent < nbytes) begin
            frm = random_frame();
            send_frame(frm);
            sent += frm.size();
        end
    endtask

    // a good frame and at least one frame per fault kind with the reset register values
    task automatic test_reset_defaults();
        byte_q_t frm;
        src_idle_pct   = 30;
        sink_stall_pct = 30;
        frm = '{8'h01, 8'h03};
        send_frame(seal(frm));
        frm = '{8'hFF};
        send_frame(frm);
        frm = '{8'h00, 8'hFF};
        send_frame(frm);
        frm = '{8'h01, 8'h03, 8'h00};
        send_frame(frm);
        frm = '{8'h00, 8'h03};
        send_frame(seal(frm));
        frm = '{8'h01, 8'h83};
        send_frame(seal(frm));
        frm = '{8'h01, 8'h04};
        send_frame(seal(frm));
        frm = '{8'h01, 8'h03};
        frm = seal(frm);
        frm[3] = frm[3] ^ 8'h01;
        send_frame(frm);
    endtask

    task automatic test_register_extremes();
        src_idle_pct   = 20;
        sink_stall_pct = 20;
        run_phase(8'h00, 8'h00, 100);
        run_phase(8'hFF, 8'hFF, 100);
        run_phase(8'hFF, 8'h00, 100);
        run_phase(8'h00, 8'h7F, 100);
    endtask

    task automatic test_random_traffic();
        int pct [4];
        pct = '{0, 10, 30, 60};
        repeat (5) begin
            src_idle_pct   = pct[$urandom_range(3)];
            sink_stall_pct = pct[$urandom_range(3)];
            run_phase(8'($urandom_range(255)), 8'($urandom_range(127)), 120);
        end
    endtask

    task automatic test_back_to_back();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        run_phase(8'($urandom_range(255)), 8'($urandom_range(127)), 250);
    endtask

    // result sink with random stalls
    initial begin
        int hold;
        hold = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold > 0) begin
                m_tready <= 1'b0;
                hold--;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(99) < sink_stall_pct) hold = pick_gap();
            end
        end
    end

    // verdict checker
    always @(posedge aclk) begin
        verdict_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_verdicts.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) $display("unexpected verdict transaction: %h", m_tdata);
            end else begin
                want = pending_verdicts.pop_front();
                if (m_tdata[0] !== want.frame_ok || m_tdata[3:1] !== want.fault_code
                        || m_tdata[19:4] !== want.computed_crc
                        || m_tdata[35:20] !== want.received_crc) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("verdict mismatch: exp ok=%0d fault=%0d crc=%h recv=%h",
                                 want.frame_ok, want.fault_code, want.computed_crc,
                                 want.received_crc);
                        $display("                  got ok=%0d fault=%0d crc=%h recv=%h",
                                 m_tdata[0], m_tdata[3:1], m_tdata[19:4], m_tdata[35:20]);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        fail_count     = 0;
        quiet_cycles   = 0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        exp_slave_reg  = RST_SLAVE;
        exp_func_reg   = RST_FUNC;
        clear_frame_model();
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_addr  <= REG_EXP_SLAVE;
        cfg_wdata <= 8'h00;
        s_tvalid  <= 1'b0;
        s_tdata   <= 8'h00;
        s_tlast   <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_register_extremes();
        test_random_traffic();
        test_back_to_back();
        wait_idle();

        if (fail_count == 0 && pending_verdicts.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
